// ===== rtl/core/pidl_pkg.sv =====
// ----------------------------------------------------------------------------
// pidl_pkg
// Types and codes shared by the positional insert/delete list and its cells.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int FUNC_W  = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS  = 2'd0,
    FN_DEL  = 2'd1,
    FN_MOD  = 2'd2,
    FN_DUMP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // what every cell does to its entry
  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_INS  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_MOD  = 3'd3,
    CELL_ROT  = 3'd4
  } cell_op_t;

  typedef struct packed {
    func_t                     func;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                   status;
    logic [POS_W-1:0]          item_index;
    logic signed [VALUE_W-1:0] item_value;
    logic                      last;
    logic [COUNT_W-1:0]        count;
  } rsp_t;

  // broadcast to the whole chain; indexes are 0-based
  typedef struct packed {
    cell_op_t                  op;
    logic [POS_W-1:0]          idx;   // target entry
    logic [POS_W-1:0]          tail;  // last valid entry
    logic signed [VALUE_W-1:0] value;
    logic signed [VALUE_W-1:0] head;  // entry 0, wraps to the tail on rotate
  } cell_ctrl_t;

endpackage

// ===== rtl/core/pidl_cell.sv =====
// ----------------------------------------------------------------------------
// pidl_cell
// One list entry. Loads, shifts from a neighbor or holds, as the chain
// control says.
// ----------------------------------------------------------------------------
module pidl_cell #(
  parameter int INDEX = 0
) (
  input  logic                                clk,
  input  pidl_pkg::cell_ctrl_t                ctrl,
  input  logic signed [pidl_pkg::VALUE_W-1:0] left,
  input  logic signed [pidl_pkg::VALUE_W-1:0] right,
  output logic signed [pidl_pkg::VALUE_W-1:0] data
);

  localparam logic [pidl_pkg::POS_W-1:0] MY_IDX = pidl_pkg::POS_W'(INDEX);

  logic signed [pidl_pkg::VALUE_W-1:0] data_next;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      pidl_pkg::CELL_INS: begin
        if (MY_IDX > ctrl.idx) begin
          data_next = left;
        end else if (MY_IDX == ctrl.idx) begin
          data_next = ctrl.value;
        end
      end
      pidl_pkg::CELL_DEL: begin
        if (MY_IDX >= ctrl.idx) begin
          data_next = right;
        end
      end
      pidl_pkg::CELL_MOD: begin
        if (MY_IDX == ctrl.idx) begin
          data_next = ctrl.value;
        end
      end
      pidl_pkg::CELL_ROT: begin
        if (MY_IDX == ctrl.tail) begin
          data_next = ctrl.head;
        end else if (MY_IDX < ctrl.tail) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// ===== rtl/core/positional_insert_delete_list.sv =====
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words kept in a chain of cells: insert, delete,
// modify at a 1-based position, and dump of the whole list.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------------
//  cmd     | cmd_valid | cmd_stall | cmd : func, position, value
//  rsp     | rsp_valid | rsp_stall | rsp : status, item_index, item_value,
//          |           |           |       last, count
//
// Insert, delete and modify give one item each.
// A dump gives one item per cycle while rsp_stall is low, length items in all,
// by rotating the chain through entry 0; an empty dump gives one item.
// One command is held in a pending register, so one new command can be taken
// while a result waits on rsp_stall. Reset empties the list; entry
// contents are not cleared.
// ----------------------------------------------------------------------------
module positional_insert_delete_list #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  pidl_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output pidl_pkg::rsp_t rsp
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = ((LW > pidl_pkg::POS_W) ? LW : pidl_pkg::POS_W) + 1;

  logic                                pend_valid;
  pidl_pkg::cmd_t                      pend;
  logic [LW-1:0]                       len;
  logic [LW-1:0]                       len_next;
  logic [LW-1:0]                       dcnt;
  logic                                fire;
  logic                                done;
  logic                                dumping;
  logic                                dump_last;
  logic [CW-1:0]                       pos_x;
  logic [CW-1:0]                       len_x;
  pidl_pkg::status_t                   status;
  pidl_pkg::cell_op_t                  op;
  pidl_pkg::cell_ctrl_t                ctrl;
  logic signed [pidl_pkg::VALUE_W-1:0] cell_data [DEPTH];

  assign fire      = pend_valid && (!rsp_valid || !rsp_stall);
  assign dumping   = (pend.func == pidl_pkg::FN_DUMP) && (len != '0);
  assign dump_last = (dcnt == len - LW'(1));
  assign done      = fire && (!dumping || dump_last);
  assign cmd_stall = pend_valid && !done;

  assign pos_x = CW'(pend.position);
  assign len_x = CW'(len);

  always_comb begin
    status   = pidl_pkg::ST_OK;
    op       = pidl_pkg::CELL_HOLD;
    len_next = len;
    case (pend.func)
      pidl_pkg::FN_INS: begin
        if (pos_x == '0 || pos_x > len_x + CW'(1)) begin
          status = pidl_pkg::ST_RANGE;
        end else if (len_x == CW'(DEPTH)) begin
          status = pidl_pkg::ST_FULL;
        end else begin
          op       = pidl_pkg::CELL_INS;
          len_next = len + LW'(1);
        end
      end
      pidl_pkg::FN_DEL: begin
        if (pos_x == '0 || pos_x > len_x) begin
          status = pidl_pkg::ST_RANGE;
        end else begin
          op       = pidl_pkg::CELL_DEL;
          len_next = len - LW'(1);
        end
      end
      pidl_pkg::FN_MOD: begin
        if (pos_x == '0 || pos_x > len_x) begin
          status = pidl_pkg::ST_RANGE;
        end else begin
          op = pidl_pkg::CELL_MOD;
        end
      end
      pidl_pkg::FN_DUMP: begin
        if (len == '0) begin
          status = pidl_pkg::ST_EMPTY;
        end else begin
          op = pidl_pkg::CELL_ROT;
        end
      end
      default: status = pidl_pkg::ST_OK;
    endcase
  end

  always_comb begin
    ctrl.op    = fire ? op : pidl_pkg::CELL_HOLD;
    ctrl.idx   = pend.position - pidl_pkg::POS_W'(1);
    ctrl.tail  = pidl_pkg::POS_W'(len - LW'(1));
    ctrl.value = pend.value;
    ctrl.head  = cell_data[0];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [pidl_pkg::VALUE_W-1:0] left;
    logic signed [pidl_pkg::VALUE_W-1:0] right;
    if (i == 0) begin : g_first
      assign left = cell_data[i];
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end
    pidl_cell #(.INDEX(i)) u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .left  (left),
      .right (right),
      .data  (cell_data[i])
    );
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
      len        <= '0;
      dcnt       <= '0;
    end else begin
      if (cmd_valid && !cmd_stall) begin
        pend_valid <= 1'b1;
      end else if (done) begin
        pend_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
        len       <= len_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (fire && dumping) begin
        dcnt <= dump_last ? '0 : dcnt + LW'(1);
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      pend <= cmd;
    end
    if (fire) begin
      rsp.status     <= status;
      rsp.item_index <= dumping ? pidl_pkg::POS_W'(dcnt + LW'(1)) : '0;
      rsp.item_value <= dumping ? cell_data[0] : '0;
      rsp.last       <= !dumping || dump_last;
      rsp.count      <= pidl_pkg::COUNT_W'(len_next);
    end
  end

endmodule

// ===== rtl/core/pidl_checker.sv =====
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks on the positional insert/delete list.
// ----------------------------------------------------------------------------
module pidl_checker #(
  parameter int DEPTH = 32
) (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input pidl_pkg::rsp_t rsp
);

  // a stalled result item holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp item changed under stall");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("rsp_valid after reset");

  // only dump items can be non-final, and they are always ok
  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == pidl_pkg::ST_OK && rsp.item_index != '0)
    else $error("non-final item is not a dump element");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pidl_pkg::ST_OK |->
      rsp.item_index == '0 && rsp.item_value == '0 && rsp.last)
    else $error("error item carries data");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == pidl_pkg::ST_FULL |->
      rsp.count == pidl_pkg::COUNT_W'(DEPTH))
    else $error("full status with short list");

endmodule

bind positional_insert_delete_list pidl_checker #(.DEPTH(DEPTH)) u_pidl_checker (.*);
